/* rtl/prqs_pkg.sv */
// Shared constants, types and helpers for the priority ready queue scheduler.
// No dependencies.
`timescale 1ns / 1ps

package prqs_pkg;

  localparam int NumTasks  = 64;
  localparam int NumLevels = 32;
  localparam int TaskW     = $clog2(NumTasks);
  localparam int LevelW    = $clog2(NumLevels);

  typedef logic [TaskW-1:0]  task_t;
  typedef logic [LevelW-1:0] level_t;

  typedef enum logic [1:0] {
    StQueued     = 2'd0,
    StIgnored    = 2'd1,
    StDispatched = 2'd2,
    StEmpty      = 2'd3
  } status_e;

  // highest set bit of a level mask, zero when the mask is empty
  function automatic level_t highest_set(logic [NumLevels-1:0] mask);
    level_t idx;
    idx = '0;
    for (int i = 0; i < NumLevels; i++) begin
      if (mask[i]) idx = level_t'(i);
    end
    return idx;
  endfunction

endpackage

/* rtl/priority_ready_queue_scheduler.sv */
// Top level of the priority ready queue scheduler: per-level FIFO queues of tasks.
// Depends on prqs_pkg.
`timescale 1ns / 1ps

// Usage:
//   Command channel: start_i with mode_i (0 mark ready, 1 dispatch), task_id_i and
//   task_priority_i. A word is taken at a rising edge with start_i high and busy_o low.
//   Result channel: done_o is high for exactly one cycle with status_o and
//   chosen_task_o; the receiver must take it then, it cannot stall the block.
//   Timing: an accepted word is held in the payload registers and in the registered
//   read of the link and tail memories while busy_o is high, and its result is
//   registered from them. busy_o is registered from the accept, so a new word is
//   not taken before the queue update for the last one has been made.
//   The next word may be accepted while a result is still on the result ports.
//   Higher task_priority is served first; within a level, first in first out.
//   Status: 0 queued, 1 task already ready (ignored), 2 dispatched, 3 nothing ready.
//   Reset (rst_ni low, asynchronous): no task is ready, every queue is empty and no
//   result is pending. The link, head and tail stores hold no reset value and are
//   only read after being written. No clearing pass is needed.
module priority_ready_queue_scheduler
  import prqs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              mode_i,
  input  logic [TaskW-1:0]  task_id_i,
  input  logic [LevelW-1:0] task_priority_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [TaskW-1:0]  chosen_task_o
);

  logic                 busy_q, done_q;
  status_e              status_q;
  task_t                chosen_q;

  logic                 mode_q;
  task_t                task_q;
  level_t               prio_q;

  task_t                link_mem [NumTasks];
  task_t                tail_mem [NumLevels];
  task_t                link_rd_q, tail_rd_q;
  task_t                head_q   [NumLevels];

  logic [NumTasks-1:0]  ready_q;
  logic [NumLevels-1:0] nonempty_q;
  logic                 top_valid_q;
  level_t               top_level_q;

  logic                 accept;
  task_t                head_top;
  logic                 mark_ok, disp_ok, last;
  logic                 link_we, tail_we, head_we;
  level_t               head_wa;
  task_t                head_wd;
  logic [NumLevels-1:0] ne_rest;

  assign accept   = start_i & ~busy_q;
  assign head_top = head_q[top_level_q];

  assign mark_ok  = busy_q & ~mode_q & ~ready_q[task_q];
  assign disp_ok  = busy_q & mode_q & top_valid_q;
  assign last     = (head_top == tail_rd_q);

  assign link_we  = mark_ok & nonempty_q[prio_q];
  assign tail_we  = mark_ok;
  assign head_we  = (mark_ok & ~nonempty_q[prio_q]) | (disp_ok & ~last);
  assign head_wa  = mode_q ? top_level_q : prio_q;
  assign head_wd  = mode_q ? link_rd_q : task_q;

  always_comb begin
    ne_rest = nonempty_q;
    ne_rest[top_level_q] = 1'b0;
  end

  // memories and payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_i;
      task_q    <= task_id_i;
      prio_q    <= task_priority_i;
      link_rd_q <= link_mem[head_top];
      tail_rd_q <= tail_mem[mode_i ? top_level_q : task_priority_i];
    end
    if (link_we) begin
      link_mem[tail_rd_q] <= task_q;
    end
    if (tail_we) begin
      tail_mem[prio_q] <= task_q;
    end
    if (head_we) begin
      head_q[head_wa] <= head_wd;
    end
  end

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      status_q    <= StQueued;
      chosen_q    <= '0;
      ready_q     <= '0;
      nonempty_q  <= '0;
      top_valid_q <= 1'b0;
      top_level_q <= '0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (busy_q) begin
        priority if (!mode_q && !mark_ok) begin
          status_q <= StIgnored;
          chosen_q <= '0;
        end else if (!mode_q) begin
          status_q <= StQueued;
          chosen_q <= '0;
        end else if (!disp_ok) begin
          status_q <= StEmpty;
          chosen_q <= '0;
        end else begin
          status_q <= StDispatched;
          chosen_q <= head_top;
        end
      end
      if (mark_ok) begin
        ready_q[task_q]    <= 1'b1;
        nonempty_q[prio_q] <= 1'b1;
        if (!top_valid_q || prio_q > top_level_q) begin
          top_level_q <= prio_q;
          top_valid_q <= 1'b1;
        end
      end
      if (disp_ok) begin
        ready_q[head_top] <= 1'b0;
        if (last) begin
          nonempty_q  <= ne_rest;
          top_valid_q <= |ne_rest;
          top_level_q <= highest_set(ne_rest);
        end
      end
    end
  end

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign chosen_task_o = chosen_q;

`ifndef SYNTHESIS
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o && !busy_o)
    else $error("result strobe missing after accepted word");

  a_chosen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StDispatched |-> chosen_task_o == '0)
    else $error("chosen task non-zero without dispatch");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !top_valid_q |-> nonempty_q == '0)
    else $error("non-empty level while no top level");

  a_top_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_valid_q |-> nonempty_q[top_level_q])
    else $error("top level points at an empty queue");
`endif

endmodule
